// ===== rtl/lev_pkg.sv =====
// Shared constants and helpers for the local-to-ECEF velocity datapath.
package lev_pkg;

  // Angle and trig formats
  localparam int unsigned AngW    = 32;
  localparam int unsigned TrigW   = 34;
  localparam int unsigned CordicN = 30;
  localparam int unsigned SpeedW  = 32;

  // Divider and root formats
  localparam int unsigned DivSteps = 32;
  localparam int unsigned QuoW     = 33;
  localparam int unsigned RootSteps = 32;

  // Fixed-point constants (Q30)
  localparam logic signed [TrigW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [31:0]      TiltG      = 32'sd7236480;
  localparam logic [31:0]             OneQ30     = 32'h4000_0000;

  // Register map
  localparam logic RegEarthModel = 1'b0;
  localparam logic ModelSphere   = 1'b1;

  // Pipeline depths, counted in register stages from the accept edge
  localparam int unsigned LatCordic = CordicN + 2;
  localparam int unsigned LatDiv    = DivSteps + 2;
  localparam int unsigned DTrig     = LatCordic;
  localparam int unsigned DP1       = DTrig + 1;
  localparam int unsigned DP2       = DTrig + 2;
  localparam int unsigned DMu       = DP2 + LatDiv;
  localparam int unsigned DP3       = DMu + 1;
  localparam int unsigned DP4       = DMu + 2;
  localparam int unsigned DRoot     = DP4 + RootSteps;
  localparam int unsigned DAb       = DRoot + LatDiv;
  localparam int unsigned DM1       = DAb + 1;
  localparam int unsigned DM2       = DAb + 2;
  localparam int unsigned DOut      = DAb + 3;

  // Arctangent of 2^-i in binary-angle units (2^32 per turn)
  localparam logic [31:0] AtanTab [CordicN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Floor-shift a Q46 sum by 30 and saturate to 32 bits
  function automatic logic [SpeedW-1:0] sat_q30(input logic signed [67:0] s);
    logic signed [67:0] r;
    begin
      r = s >>> 30;
      if (r > 68'sd2147483647) begin
        sat_q30 = 32'h7FFF_FFFF;
      end else if (r < -68'sd2147483648) begin
        sat_q30 = 32'h8000_0000;
      end else begin
        sat_q30 = r[31:0];
      end
    end
  endfunction

endpackage

// ===== rtl/local_to_ecef_velocity_top.sv =====
// Top level: east/north surface velocity to Earth-centred velocity.
//
// Input channel (in_valid_i/in_ready_o) carries east_speed_i, north_speed_i
// (Q15.16 m/s), longitude_i and latitude_i (binary angles, 2^32 per turn).
// Output channel (out_valid_o/out_ready_i) carries x_speed_o, y_speed_o and
// z_speed_o, rounded and saturated Q15.16 m/s. One result beat per input beat.
// The APB port holds earth_model at address 0: 0 selects the WGS84 surface
// normal, 1 a sphere; write it only while the pipeline is empty.
// Throughput: one beat per cycle while the output is not held. Each beat passes
// two 30-step CORDIC rows, a 32-step divider for the tilt term, a 32-step
// square root and a second 32-step divider row, plus multiply stages.
// All stages advance together; when the output holds an unaccepted result
// and out_ready_i is low, the whole pipeline holds and in_ready_o drops.
// Reset clears the valid bits and earth_model; no clearing pass is needed.
module local_to_ecef_velocity_top import lev_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [SpeedW-1:0] east_speed_i,
  input  logic signed [SpeedW-1:0] north_speed_i,
  input  logic signed [AngW-1:0]   longitude_i,
  input  logic signed [AngW-1:0]   latitude_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SpeedW-1:0] x_speed_o,
  output logic signed [SpeedW-1:0] y_speed_o,
  output logic signed [SpeedW-1:0] z_speed_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic en;
  logic earth_model_q;
  logic vld_q [1:DOut];

  // Advance when the output slot is free or being taken
  assign en         = !vld_q[DOut] || out_ready_i;
  assign in_ready_o = en;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegEarthModel) ? {31'b0, earth_model_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      earth_model_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == RegEarthModel)) begin
      earth_model_q <= pwdata[0];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= DOut; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= in_valid_i;
      for (int k = 2; k <= DOut; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Trig units
  logic signed [TrigW-1:0] clon_w, slon_w, clat_w, slat_w;

  lev_cordic u_cordic_lon (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (longitude_i),
    .cos_o   (clon_w),
    .sin_o   (slon_w)
  );

  lev_cordic u_cordic_lat (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (latitude_i),
    .cos_o   (clat_w),
    .sin_o   (slat_w)
  );

  // Delay lines for speeds and trig values
  logic signed [SpeedW-1:0] u_q [1:DM1];
  logic signed [SpeedW-1:0] v_q [1:DM2];
  logic signed [TrigW-1:0]  clon_q [DP1:DAb];
  logic signed [TrigW-1:0]  slon_q [DP1:DAb];
  logic signed [TrigW-1:0]  clat_q [DP1:DP3];
  logic signed [TrigW-1:0]  slat_q [DP1:DP3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q[1] <= east_speed_i;
      v_q[1] <= north_speed_i;
      for (int k = 2; k <= DM1; k++) u_q[k] <= u_q[k-1];
      for (int k = 2; k <= DM2; k++) v_q[k] <= v_q[k-1];
      clon_q[DP1] <= clon_w;
      slon_q[DP1] <= slon_w;
      clat_q[DP1] <= clat_w;
      slat_q[DP1] <= slat_w;
      for (int k = DP1 + 1; k <= DAb; k++) begin
        clon_q[k] <= clon_q[k-1];
        slon_q[k] <= slon_q[k-1];
      end
      for (int k = DP1 + 1; k <= DP3; k++) begin
        clat_q[k] <= clat_q[k-1];
        slat_q[k] <= slat_q[k-1];
      end
    end
  end

  // Tilt term, first products: s^2 and g*s
  logic signed [67:0] ss_w;
  logic signed [65:0] gsl_w;
  logic signed [32:0] s2_q;
  logic signed [24:0] t_q;

  assign ss_w  = slat_w * slat_w;
  assign gsl_w = TiltG * slat_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= ss_w[62:30];
      t_q  <= gsl_w[54:30];
    end
  end

  // Tilt term: denominator and numerator; sphere forces zero
  logic signed [64:0] gs2_w;
  logic signed [63:0] tc_w;
  logic [31:0]        den_q;
  logic signed [63:0] mnum_q;

  assign gs2_w = TiltG * s2_q;
  assign tc_w  = t_q * clat_q[DP1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q  <= OneQ30 + gs2_w[61:30];
      mnum_q <= (earth_model_q == ModelSphere) ? '0 : tc_w;
    end
  end

  logic signed [QuoW-1:0] mu_w;

  lev_div u_div_mu (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mnum_q),
    .den_i (den_q),
    .quo_o (mu_w)
  );

  // mu^2 and the cross products of mu with the latitude trig
  logic signed [65:0] mm_w;
  logic signed [63:0] mc_w, ms_w;
  logic [17:0]        m2_q;
  logic signed [63:0] mc_q, ms_q;

  assign mm_w = mu_w * mu_w;
  assign mc_w = mu_w * clat_q[DMu];
  assign ms_w = mu_w * slat_q[DMu];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_q <= mm_w[47:30];
      mc_q <= mc_w;
      ms_q <= ms_w;
    end
  end

  // North-axis numerators and the root operand
  logic signed [63:0] slx_w, clx_w;
  logic signed [63:0] na_q [DP4:DRoot];
  logic signed [63:0] nb_q [DP4:DRoot];
  logic [63:0]        sqn_q [0:RootSteps];
  logic [63:0]        sqr_q [0:RootSteps];

  assign slx_w = {{(64-TrigW){slat_q[DP3][TrigW-1]}}, slat_q[DP3]};
  assign clx_w = {{(64-TrigW){clat_q[DP3][TrigW-1]}}, clat_q[DP3]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      na_q[DP4] <= (slx_w <<< 30) + mc_q;
      nb_q[DP4] <= (clx_w <<< 30) - ms_q;
      for (int k = DP4 + 1; k <= DRoot; k++) begin
        na_q[k] <= na_q[k-1];
        nb_q[k] <= nb_q[k-1];
      end
      sqn_q[0] <= ({46'b0, m2_q} + 64'(OneQ30)) << 30;
      sqr_q[0] <= '0;
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    logic [63:0] bit_w;
    logic [63:0] trial_w;
    assign bit_w   = 64'd1 << (62 - 2 * k);
    assign trial_w = sqr_q[k] + bit_w;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sqn_q[k] >= trial_w) begin
          sqn_q[k+1] <= sqn_q[k] - trial_w;
          sqr_q[k+1] <= (sqr_q[k] >> 1) + bit_w;
        end else begin
          sqn_q[k+1] <= sqn_q[k];
          sqr_q[k+1] <= sqr_q[k] >> 1;
        end
      end
    end
  end

  logic [31:0] root_w;
  assign root_w = sqr_q[RootSteps][31:0];

  // Normalize the north axis
  logic signed [QuoW-1:0] a_w, b_w;

  lev_div u_div_a (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (na_q[DRoot]),
    .den_i (root_w),
    .quo_o (a_w)
  );

  lev_div u_div_b (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nb_q[DRoot]),
    .den_i (root_w),
    .quo_o (b_w)
  );

  // First product row
  logic signed [66:0] ac_w, as_w;
  logic signed [65:0] us_w, uc_w, vb_w;
  logic signed [TrigW-1:0] ac_q, as_q;
  logic signed [65:0] us_q, uc_q, vb_q;

  assign ac_w = a_w * clon_q[DAb];
  assign as_w = a_w * slon_q[DAb];
  assign us_w = u_q[DAb] * slon_q[DAb];
  assign uc_w = u_q[DAb] * clon_q[DAb];
  assign vb_w = v_q[DAb] * b_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ac_q <= ac_w[63:30];
      as_q <= as_w[63:30];
      us_q <= us_w;
      uc_q <= uc_w;
      vb_q <= vb_w;
    end
  end

  // Second product row
  logic signed [65:0] vac_w, vas_w;
  logic signed [65:0] vac_q, vas_q, us2_q, uc2_q, vb2_q;

  assign vac_w = v_q[DM1] * ac_q;
  assign vas_w = v_q[DM1] * as_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vac_q <= vac_w;
      vas_q <= vas_w;
      us2_q <= us_q;
      uc2_q <= uc_q;
      vb2_q <= vb_q;
    end
  end

  // Sum, round half up, saturate
  logic signed [67:0] xs_w, ys_w, zs_w;
  logic [SpeedW-1:0]  x_q, y_q, z_q;

  assign xs_w = 68'sd536870912 - us2_q - vac_q;
  assign ys_w = 68'sd536870912 + uc2_q - vas_q;
  assign zs_w = 68'sd536870912 + vb2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= sat_q30(xs_w);
      y_q <= sat_q30(ys_w);
      z_q <= sat_q30(zs_w);
    end
  end

  assign out_valid_o = vld_q[DOut];
  assign x_speed_o   = $signed(x_q);
  assign y_speed_o   = $signed(y_q);
  assign z_speed_o   = $signed(z_q);

  // A held output freezes the first and the root-stage valid bits
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (vld_q[1] == $past(vld_q[1])) && (vld_q[DRoot] == $past(vld_q[DRoot])))
    else $error("pipeline moved during a stall");

  // Tilt denominator never drops below one
  a_den_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DP2] |-> (den_q >= OneQ30))
    else $error("tilt denominator below one");

  // Root of a value of at least one is at least one
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DRoot] |-> (root_w >= OneQ30))
    else $error("normalizing root below one");

endmodule

// ===== rtl/lev_cordic.sv =====
// Pipelined rotation-mode CORDIC: cosine and sine of a 32-bit binary angle.
module lev_cordic import lev_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [AngW-1:0]         angle_i,
  output logic signed [TrigW-1:0] cos_o,
  output logic signed [TrigW-1:0] sin_o
);

  logic signed [TrigW-1:0] x_q [0:CordicN];
  logic signed [TrigW-1:0] y_q [0:CordicN];
  logic signed [TrigW-1:0] z_q [0:CordicN];
  logic                    neg_q [0:CordicN];
  logic signed [TrigW-1:0] cos_q, sin_q;

  logic [AngW-1:0] turn_w;
  logic [AngW-1:0] ang_w;
  logic            fold_w;

  // Fold the angle into [-90, 90) degrees
  assign turn_w = angle_i + 32'h4000_0000;
  assign fold_w = turn_w[AngW-1];
  assign ang_w  = fold_w ? (angle_i + 32'h8000_0000) : angle_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= CordicGain;
      y_q[0]   <= '0;
      z_q[0]   <= {{(TrigW-AngW){ang_w[AngW-1]}}, ang_w};
      neg_q[0] <= fold_w;
    end
  end

  // One micro-rotation per stage
  for (genvar k = 0; k < CordicN; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][TrigW-1]) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - TrigW'(AtanTab[k]);
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + TrigW'(AtanTab[k]);
        end
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= neg_q[CordicN] ? -x_q[CordicN] : x_q[CordicN];
      sin_q <= neg_q[CordicN] ? -y_q[CordicN] : y_q[CordicN];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ===== rtl/lev_div.sv =====
// Pipelined restoring divider: signed 64-bit dividend by positive 32-bit divisor.
module lev_div import lev_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [63:0]     num_i,
  input  logic [31:0]            den_i,
  output logic signed [QuoW-1:0] quo_o
);

  logic [63:0]          rem_q [0:DivSteps];
  logic [31:0]          den_q [0:DivSteps];
  logic [DivSteps-1:0]  quo_q [0:DivSteps];
  logic                 sgn_q [0:DivSteps];
  logic signed [QuoW-1:0] res_q;

  // Split off the sign, keep the magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[63] ? 64'(-num_i) : 64'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sgn_q[0] <= num_i[63];
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [63:0] trial_w;
    assign trial_w = {32'b0, den_q[k]} << (DivSteps - 1 - k);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1] <= den_q[k];
        sgn_q[k+1] <= sgn_q[k];
        if (rem_q[k] >= trial_w) begin
          rem_q[k+1] <= rem_q[k] - trial_w;
          quo_q[k+1] <= quo_q[k] | (DivSteps'(1) << (DivSteps - 1 - k));
        end else begin
          rem_q[k+1] <= rem_q[k];
          quo_q[k+1] <= quo_q[k];
        end
      end
    end
  end

  // Restore the sign: truncation toward zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= sgn_q[DivSteps] ? -$signed({1'b0, quo_q[DivSteps]})
                               : $signed({1'b0, quo_q[DivSteps]});
    end
  end

  assign quo_o = res_q;

endmodule
